// File: rtl/cft_pkg.sv
package cft_pkg;

    // Default limit on the number of columns in one row.
    localparam int unsigned MAX_COLUMNS_DEF = 256;

    // Fixed byte values of the text format.
    localparam logic [7:0] QUOTE_BYTE    = 8'd34;
    localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
    localparam logic [7:0] SEPARATOR_RST = 8'd44;

    // Result kinds, carried on the output tuser.
    localparam logic [1:0] KIND_CONTENT   = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_UNCLOSED_QUOTE = 2'd0;
    localparam logic [1:0] ERR_COL_MISMATCH   = 2'd1;
    localparam logic [1:0] ERR_TOO_MANY_COLS  = 2'd2;

    // One result item as handed from the parser to the output register.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] content_byte;
        logic [7:0] column_index;
        logic       row_end;
        logic [1:0] error_code;
    } t_result;

endpackage

// File: rtl/cft_parser.sv
module cft_parser #(
    parameter int unsigned MAX_COLUMNS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_input,
    input  logic [7:0]       i_separator_char,
    output logic             o_res_valid,
    output cft_pkg::t_result o_res
);
    import cft_pkg::*;

    localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] MAX_COL = CW'(MAX_COLUMNS);

    logic          r_inq, n_inq;
    logic          r_qp, n_qp;
    logic          r_fo, n_fo;
    logic          r_halted, n_halted;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_exp, n_exp;

    logic          unquoted;
    logic          row_end;
    logic          do_end;
    logic [CW-1:0] count;
    logic [CW+7:0] col_wide;

    assign count    = r_col + 1'b1;
    assign col_wide = {8'd0, r_col};

    always_comb begin
        n_inq       = r_inq;
        n_qp        = r_qp;
        n_fo        = r_fo;
        n_halted    = r_halted;
        n_col       = r_col;
        n_exp       = r_exp;
        o_res_valid = 1'b0;
        o_res       = '0;
        unquoted    = 1'b0;
        do_end      = 1'b0;
        row_end     = 1'b0;

        if (i_en) begin
            if (i_end_of_input) begin
                if (!r_halted) begin
                    if (r_inq && !r_qp) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_UNCLOSED_QUOTE;
                    end else if (r_fo || r_col != '0) begin
                        do_end  = 1'b1;
                        row_end = 1'b1;
                    end
                end
            end else if (!r_halted) begin
                if (r_qp) begin
                    n_qp = 1'b0;
                    if (i_text_byte == QUOTE_BYTE) begin
                        // Doubled quote inside quotes gives one quote byte.
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_CONTENT;
                        o_res.content_byte = i_text_byte;
                    end else begin
                        n_inq    = 1'b0;
                        unquoted = 1'b1;
                    end
                end else if (r_inq) begin
                    if (i_text_byte == QUOTE_BYTE) begin
                        n_qp = 1'b1;
                    end else begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_CONTENT;
                        o_res.content_byte = i_text_byte;
                    end
                end else begin
                    unquoted = 1'b1;
                end

                if (unquoted) begin
                    priority if (i_text_byte == QUOTE_BYTE) begin
                        n_inq = 1'b1;
                        n_fo  = 1'b1;
                    end else if (i_text_byte == i_separator_char ||
                                 i_text_byte == NEWLINE_BYTE) begin
                        do_end  = 1'b1;
                        row_end = (i_text_byte == NEWLINE_BYTE);
                    end else begin
                        n_fo               = 1'b1;
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_CONTENT;
                        o_res.content_byte = i_text_byte;
                    end
                end
            end

            if (do_end) begin
                o_res_valid = 1'b1;
                priority if (r_col >= MAX_COL) begin
                    n_halted         = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_TOO_MANY_COLS;
                end else if (row_end && r_exp != '0 && count != r_exp) begin
                    n_fo             = 1'b0;
                    n_halted         = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_COL_MISMATCH;
                end else begin
                    n_fo               = 1'b0;
                    o_res.kind         = KIND_FIELD_END;
                    o_res.column_index = col_wide[7:0];
                    o_res.row_end      = row_end;
                    if (row_end) begin
                        n_col = '0;
                        if (r_exp == '0) begin
                            n_exp = count;
                        end
                    end else begin
                        n_col = count;
                    end
                end
            end

            // End of input starts a fresh stream, first-row count included.
            if (i_end_of_input) begin
                n_inq    = 1'b0;
                n_qp     = 1'b0;
                n_fo     = 1'b0;
                n_halted = 1'b0;
                n_col    = '0;
                n_exp    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq    <= 1'b0;
            r_qp     <= 1'b0;
            r_fo     <= 1'b0;
            r_halted <= 1'b0;
            r_col    <= '0;
            r_exp    <= '0;
        end else begin
            r_inq    <= n_inq;
            r_qp     <= n_qp;
            r_fo     <= n_fo;
            r_halted <= n_halted;
            r_col    <= n_col;
            r_exp    <= n_exp;
        end
    end

`ifndef SYNTH
    a_pending_needs_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qp |-> r_inq)
        else $error("pending quote outside quoted mode");

    a_column_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= MAX_COL && r_exp <= MAX_COL)
        else $error("column counter beyond limit");

    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_end_of_input) |=> (r_col == '0 && r_exp == '0 && !r_halted && !r_inq))
        else $error("end of input did not clear the parse state");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && i_en && !i_end_of_input) |-> !o_res_valid)
        else $error("result produced while halted");
`endif

endmodule

// File: rtl/csv_field_tokenizer_top.sv
// CSV field tokenizer.
// The slave stream takes one item per text byte: tdata carries the byte and
// tuser flags an end-of-input mark, which carries no byte. The master stream
// gives at most one result item per input item: content bytes of fields,
// field ends with their column index, and errors. tuser gives the result
// kind and tlast is set on a field end that closes its row.
// The separator byte is written through the configuration channel, which is
// always ready; write it only while the block is idle.
// A result is offered from the result register, which the parse logic loads
// from the input register that holds the accepted item.
// Throughput is one item per cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more; tready drops only when both are full.
// A synchronous reset empties both registers, clears the parse state and
// restores the separator to a comma.
module csv_field_tokenizer_top #(
    parameter int unsigned MAX_COLUMNS = cft_pkg::MAX_COLUMNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tuser,   // [0] end_of_input
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] content_byte, [15:8] column_index,
                                     // [17:16] error_code, [23:18] zero
    output logic [1:0]  o_m_tuser,   // [1:0] result_kind
    output logic        o_m_tlast,   // row_end
    // Separator configuration.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import cft_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic [7:0] r_sep;
    logic       r_out_valid;
    t_result    r_out;

    logic       parse_now;
    logic       res_valid;
    t_result    res;

    // The input item is parsed once the result register can take its result.
    assign parse_now  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || parse_now;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_eoi  <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEPARATOR_RST;
        end else if (i_cfg_valid) begin
            r_sep <= i_cfg_data;
        end
    end

    cft_parser #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (parse_now),
        .i_text_byte      (r_in_byte),
        .i_end_of_input   (r_in_eoi),
        .i_separator_char (r_sep),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    // Result register: refilled when empty or when its item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= parse_now && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (parse_now && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.error_code, r_out.column_index, r_out.content_byte};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.row_end;

endmodule

// File: test/csv_field_tokenizer_top_tb.sv
`timescale 1ns / 1ps

module csv_field_tokenizer_top_tb;

    import cft_pkg::*;

    localparam int unsigned CLK_PERIOD    = 12;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned MAX_COLS      = MAX_COLUMNS_DEF;
    // Text and end-of-input items to generate before the stimulus stops.
    localparam int unsigned TEXT_ITEMS    = 1350;
    // Idle cycles before a separator write or a pause: an item is registered
    // at input and output, and an item that gives no result leaves no trace.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned LIMIT_CYCLES  = 500_000;

    // What one entry of the feed queue asks the driver to do.
    typedef enum logic [1:0] {
        FEED_TEXT,
        FEED_EOI,
        FEED_SEPARATOR,
        FEED_PAUSE
    } t_feed_op;

    typedef struct packed {
        t_feed_op   op;
        logic [7:0] value;
    } t_feed;

    // Clock, reset and all block inputs start at known values.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        o_cfg_ready;

    // Items waiting to be offered, and results the tokenizer still owes.
    t_feed       feed_q[$];
    t_result     tokens_due[$];
    int unsigned text_items;
    int unsigned results_seen;
    int unsigned mismatches;

    // Our own copy of the tokenizer state and of the separator register.
    logic [7:0]  tk_separator;
    bit          tk_in_quotes;
    bit          tk_quote_seen;
    bit          tk_field_started;
    bit          tk_halted;
    int unsigned tk_column;
    int unsigned tk_row_width;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    csv_field_tokenizer_top #(
        .MAX_COLUMNS (MAX_COLS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Tokenizer prediction.
    // ------------------------------------------------------------------

    function automatic void clear_tokenizer();
        tk_in_quotes     = 1'b0;
        tk_quote_seen    = 1'b0;
        tk_field_started = 1'b0;
        tk_halted        = 1'b0;
        tk_column        = 0;
        tk_row_width     = 0;
    endfunction

    function automatic void owe_result(logic [1:0] kind, logic [7:0] data,
                                       logic [7:0] column, logic last,
                                       logic [1:0] code);
        t_result r;
        r.kind         = kind;
        r.content_byte = data;
        r.column_index = column;
        r.row_end      = last;
        r.error_code   = code;
        tokens_due.push_back(r);
    endfunction

    // An error stops the tokenizer until the end of the text stream.
    function automatic void owe_error(logic [1:0] code);
        tk_halted = 1'b1;
        owe_result(KIND_ERROR, '0, '0, 1'b0, code);
    endfunction

    function automatic void owe_content(logic [7:0] data);
        owe_result(KIND_CONTENT, data, '0, 1'b0, '0);
    endfunction

    // Closes the current field, and the row with it when closes_row is set.
    function automatic void close_field(bit closes_row);
        int unsigned col;
        col = tk_column;
        if (col >= MAX_COLS) begin
            owe_error(ERR_TOO_MANY_COLS);
            return;
        end
        tk_field_started = 1'b0;
        if (closes_row) begin
            if (tk_row_width == 0) begin
                tk_row_width = col + 1;
            end else if (col + 1 != tk_row_width) begin
                owe_error(ERR_COL_MISMATCH);
                return;
            end
            tk_column = 0;
        end else begin
            tk_column = col + 1;
        end
        owe_result(KIND_FIELD_END, '0, col[7:0], closes_row, '0);
    endfunction

    // Works out the results of one accepted input item.
    function automatic void tokenize(logic [7:0] b, bit eoi);
        if (eoi) begin
            if (!tk_halted) begin
                if (tk_in_quotes && !tk_quote_seen) begin
                    owe_error(ERR_UNCLOSED_QUOTE);
                end else if (tk_field_started || tk_column != 0) begin
                    close_field(1'b1);
                end
            end
            clear_tokenizer();
            return;
        end
        if (tk_halted) return;

        if (tk_quote_seen) begin
            // A second quote is an escaped quote; anything else ends quoting
            // and is then treated as an unquoted byte.
            tk_quote_seen = 1'b0;
            if (b == QUOTE_BYTE) begin
                owe_content(b);
                return;
            end
            tk_in_quotes = 1'b0;
        end else if (tk_in_quotes) begin
            if (b == QUOTE_BYTE) begin
                tk_quote_seen = 1'b1;
            end else begin
                owe_content(b);
            end
            return;
        end

        // The quote wins over a separator set to the quote byte.
        if (b == QUOTE_BYTE) begin
            tk_in_quotes     = 1'b1;
            tk_field_started = 1'b1;
        end else if (b == tk_separator || b == NEWLINE_BYTE) begin
            close_field(b == NEWLINE_BYTE);
        end else begin
            tk_field_started = 1'b1;
            owe_content(b);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------

    function automatic void add_byte(logic [7:0] b);
        t_feed f;
        f.op    = FEED_TEXT;
        f.value = b;
        feed_q.push_back(f);
        text_items++;
    endfunction

    // The byte of an end-of-input item is ignored but still driven.
    function automatic void add_eoi(logic [7:0] junk);
        t_feed f;
        f.op    = FEED_EOI;
        f.value = junk;
        feed_q.push_back(f);
        text_items++;
    endfunction

    function automatic void add_separator(logic [7:0] sep);
        t_feed f;
        f.op    = FEED_SEPARATOR;
        f.value = sep;
        feed_q.push_back(f);
    endfunction

    function automatic void add_pause();
        t_feed f;
        f.op    = FEED_PAUSE;
        f.value = '0;
        feed_q.push_back(f);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    // A byte that means nothing special outside quotes.
    function automatic logic [7:0] plain_byte(logic [7:0] sep);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == sep || b == QUOTE_BYTE || b == NEWLINE_BYTE);
        return b;
    endfunction

    // One field: empty, plain, or quoted with escaped quotes, separators
    // and newlines inside.
    function automatic void add_field(logic [7:0] sep);
        int unsigned style;
        logic [7:0]  b;
        style = $urandom_range(9);
        if (style < 2) return;
        if (style < 6) begin
            repeat ($urandom_range(5, 1)) add_byte(plain_byte(sep));
            return;
        end
        add_byte(QUOTE_BYTE);
        repeat ($urandom_range(6)) begin
            case ($urandom_range(9))
                0:       b = QUOTE_BYTE;
                1:       b = sep;
                2:       b = NEWLINE_BYTE;
                default: b = 8'($urandom_range(255));
            endcase
            add_byte(b);
            if (b == QUOTE_BYTE) add_byte(QUOTE_BYTE);
        end
        add_byte(QUOTE_BYTE);
    endfunction

    // One text stream of a few rows, ended by an end-of-input item. Mostly
    // well formed, with an odd row width, stray bytes, a trailing separator
    // or an open quote now and then.
    function automatic void add_stream(logic [7:0] sep);
        int unsigned cols, rows, width, ending, r, c;
        cols = $urandom_range(5, 1);
        rows = $urandom_range(5, 1);
        for (r = 0; r < rows; r++) begin
            width = cols;
            if (r > 0 && $urandom_range(9) == 0)
                width = ($urandom_range(1) == 1 || cols == 1) ? cols + 1 : cols - 1;
            for (c = 0; c < width; c++) begin
                if ($urandom_range(29) == 0) add_byte(8'($urandom_range(255)));
                add_field(sep);
                if (c + 1 < width) add_byte(sep);
            end
            if (r + 1 < rows) add_byte(NEWLINE_BYTE);
        end
        ending = $urandom_range(9);
        if (ending < 5) begin
            add_byte(NEWLINE_BYTE);
        end else if (ending >= 7 && ending < 9) begin
            add_byte(sep);
        end else if (ending == 9) begin
            add_byte(QUOTE_BYTE);
            add_byte(plain_byte(sep));
        end
        add_eoi(8'($urandom_range(255)));
    endfunction

    // A row of the full column count, so every column index shows up, then
    // a row one column too wide that ends at the end of input.
    function automatic void add_wide_stream(logic [7:0] sep);
        repeat (MAX_COLS - 1) begin
            if ($urandom_range(9) == 0) add_byte(plain_byte(sep));
            add_byte(sep);
        end
        add_byte(NEWLINE_BYTE);
        repeat (MAX_COLS) add_byte(sep);
        add_eoi(8'($urandom_range(255)));
    endfunction

    // Mostly no gap, some short ones and a few long ones; now and then a
    // run of items with no gap at all.
    function automatic int unsigned idle_len(inout int unsigned calm_left);
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            calm_left = $urandom_range(80, 20);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 15);
    endfunction

    // ------------------------------------------------------------------
    // Driver. Offers the head of the feed queue and predicts each item at
    // the edge where it is accepted. Separator writes and pauses wait until
    // every owed result has come and the block has had time to settle.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : drive
        bit          nxt_valid;
        bit          nxt_cfg;
        t_feed       head;
        int unsigned gap_left;
        int unsigned settle_left;
        int unsigned tx_calm;
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left     = 0;
            settle_left  = SETTLE_CYCLES;
            tx_calm      = 0;
            tk_separator = SEPARATOR_RST;
            clear_tokenizer();
        end else begin
            nxt_valid = i_s_tvalid;
            nxt_cfg   = i_cfg_valid;
            if (i_s_tvalid && o_s_tready) begin
                head = feed_q.pop_front();
                tokenize(head.value, head.op == FEED_EOI);
                nxt_valid = 1'b0;
                gap_left  = idle_len(tx_calm);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tk_separator = i_cfg_data;
                void'(feed_q.pop_front());
                nxt_cfg = 1'b0;
            end
            if (!nxt_valid && !nxt_cfg && feed_q.size() != 0) begin
                head = feed_q[0];
                if (gap_left > 0) begin
                    gap_left--;
                end else if (head.op == FEED_TEXT || head.op == FEED_EOI) begin
                    nxt_valid = 1'b1;
                    i_s_tdata <= head.value;
                    i_s_tuser <= (head.op == FEED_EOI);
                end else if (tokens_due.size() != 0) begin
                    settle_left = SETTLE_CYCLES;
                end else if (settle_left > 0) begin
                    settle_left--;
                end else begin
                    settle_left = SETTLE_CYCLES;
                    if (head.op == FEED_SEPARATOR) begin
                        nxt_cfg = 1'b1;
                        i_cfg_data <= head.value;
                    end else begin
                        void'(feed_q.pop_front());
                    end
                end
            end
            i_s_tvalid  <= nxt_valid;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Stalls at random, and holds off long at 150 results and every
    // 600 after, so the block fills up and pushes back on its input.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : receive
        int unsigned stall_left;
        int unsigned next_hold_at;
        int unsigned rx_calm;
        if (!i_rst_n) begin
            i_m_tready  <= 1'b0;
            stall_left   = 0;
            next_hold_at = 150;
            rx_calm      = 0;
        end else begin
            if (results_seen >= next_hold_at) begin
                stall_left   = $urandom_range(500, 300);
                next_hold_at = next_hold_at + 600;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(3) == 0) stall_left = idle_len(rx_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each accepted result is compared with the oldest one owed.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (tokens_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, kind %0d tdata %06h tlast %0b",
                         $time, o_m_tuser, o_m_tdata, o_m_tlast);
            end else begin
                want = tokens_due.pop_front();
                if (o_m_tuser !== want.kind || o_m_tlast !== want.row_end ||
                    o_m_tdata !== {6'd0, want.error_code, want.column_index,
                                   want.content_byte}) begin
                    mismatches++;
                    $display("%0t: result mismatch, expected kind %0d byte %02h col %0d",
                             $time, want.kind, want.content_byte, want.column_index);
                    $display("    row_end %0b error %0d; got kind %0d byte %02h col %0d",
                             want.row_end, want.error_code, o_m_tuser, o_m_tdata[7:0],
                             o_m_tdata[15:8]);
                    $display("    row_end %0b error %0d tdata %06h",
                             o_m_tlast, o_m_tdata[17:16], o_m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of the run.
    // ------------------------------------------------------------------

    initial begin : run
        logic [7:0]  sep_plan[6];
        logic [7:0]  sep;
        int unsigned phase;
        sep_plan = '{SEPARATOR_RST, 8'h00, 8'hFF, QUOTE_BYTE, NEWLINE_BYTE, 8'h3B};

        // Directed items on the reset separator.
        add_eoi(8'hFF);             // end of input with nothing open: silent
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(SEPARATOR_RST);
        add_text("\"q\"\"\",\n");   // escaped quote, then a three-column row
        add_text("z\"w\"k\n");      // quote mid-field, closing quote then a
                                    // plain byte, row too narrow
        add_text("x");              // dropped while stopped
        add_eoi(8'h00);
        add_text("\"a");            // quote still open at the end
        add_eoi(8'h5A);
        add_text("b,");             // trailing separator closes one more field
        add_eoi(8'hA5);
        add_text("\"\"");           // end of input on a pending quote
        add_eoi(8'h0F);

        // Random streams, a new separator for each phase.
        phase = 0;
        while (text_items < TEXT_ITEMS) begin
            if (phase < 6) begin
                sep = sep_plan[phase];
            end else begin
                sep = ($urandom_range(1) == 1) ? SEPARATOR_RST : 8'($urandom_range(255));
            end
            add_separator(sep);
            if (phase == 0) add_wide_stream(sep);
            repeat ($urandom_range(3, 2)) begin
                add_stream(sep);
                if ($urandom_range(3) == 0) add_pause();
            end
            phase++;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (feed_q.size() != 0 || tokens_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // The run cannot take this long unless the block has hung.
    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cft_pkg.sv
rtl/cft_parser.sv
rtl/csv_field_tokenizer_top.sv
test/csv_field_tokenizer_top_tb.sv
